// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// Needs nothing else; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define RVD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define RVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/rvd_pkg.sv -----
// Package for the RV32I/Zicsr decoder: class codes, encoding table,
// result types. No dependencies.
package rvd_pkg;

  localparam int WORD_W  = 32;
  localparam int CLASS_W = 6;
  localparam int NUM_ENC = 49;

  typedef logic [CLASS_W-1:0] class_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              csr_imm;
  } imm_t;

  // class codes, 0 means no table entry matched
  localparam class_t CLS_NONE    = 6'd0;
  localparam class_t CLS_ADDI    = 6'd1;
  localparam class_t CLS_ANDI    = 6'd6;
  localparam class_t CLS_SLLI    = 6'd7;
  localparam class_t CLS_SRAI    = 6'd9;
  localparam class_t CLS_LUI     = 6'd20;
  localparam class_t CLS_AUIPC   = 6'd21;
  localparam class_t CLS_JAL     = 6'd22;
  localparam class_t CLS_JALR    = 6'd23;
  localparam class_t CLS_BEQ     = 6'd24;
  localparam class_t CLS_BGEU    = 6'd29;
  localparam class_t CLS_LB      = 6'd30;
  localparam class_t CLS_LHU     = 6'd34;
  localparam class_t CLS_SB      = 6'd35;
  localparam class_t CLS_SW      = 6'd37;
  localparam class_t CLS_FENCE   = 6'd38;
  localparam class_t CLS_FENCE_I = 6'd39;
  localparam class_t CLS_CSRRWI  = 6'd47;
  localparam class_t CLS_CSRRSI  = 6'd48;
  localparam class_t CLS_CSRRCI  = 6'd49;

  localparam logic [31:0] OPC_MASK   = 32'h0000_007F;
  localparam logic [31:0] F3_MASK    = 32'h0000_7000;
  localparam logic [31:0] F7_MASK    = 32'hFE00_0000;
  localparam logic [31:0] F12_MASK   = 32'hFFF0_0000;
  localparam logic [31:0] UPPER_MASK = 32'hFFFF_F000;
  localparam logic [31:0] M_OF3      = OPC_MASK | F3_MASK;
  localparam logic [31:0] M_OF37     = OPC_MASK | F3_MASK | F7_MASK;
  localparam logic [31:0] M_ALL      = 32'hFFFF_FFFF;

  localparam logic [31:0] ENC_ECALL  = 32'h0000_0073;
  localparam logic [31:0] ENC_EBREAK = 32'h0010_0073;
  localparam logic [31:0] ENC_MRET   = 32'h3020_0073;
  localparam logic [31:0] ENC_WFI    = 32'h1050_0073;

  localparam logic [31:0] ENC_MASK [NUM_ENC] = '{
    M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3,
    M_OF37, M_OF37, M_OF37, M_OF37, M_OF37, M_OF37, M_OF37,
    M_OF37, M_OF37, M_OF37, M_OF37, M_OF37, M_OF37,
    OPC_MASK, OPC_MASK, OPC_MASK,
    M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3,
    M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3,
    M_OF3, M_OF3 | F12_MASK,
    M_ALL, M_ALL, M_ALL, M_ALL,
    M_OF3, M_OF3, M_OF3, M_OF3, M_OF3, M_OF3
  };

  localparam logic [31:0] ENC_MATCH [NUM_ENC] = '{
    32'h0000_0013, 32'h0000_2013, 32'h0000_3013,
    32'h0000_4013, 32'h0000_6013, 32'h0000_7013,
    32'h0000_1013, 32'h0000_5013, 32'h4000_5013,
    32'h0000_0033, 32'h4000_0033, 32'h0000_1033,
    32'h0000_2033, 32'h0000_3033, 32'h0000_4033,
    32'h0000_5033, 32'h4000_5033, 32'h0000_6033,
    32'h0000_7033,
    32'h0000_0037, 32'h0000_0017,
    32'h0000_006F, 32'h0000_0067,
    32'h0000_0063, 32'h0000_1063, 32'h0000_4063,
    32'h0000_5063, 32'h0000_6063, 32'h0000_7063,
    32'h0000_0003, 32'h0000_1003, 32'h0000_2003,
    32'h0000_4003, 32'h0000_5003,
    32'h0000_0023, 32'h0000_1023, 32'h0000_2023,
    32'h0000_000F, 32'h0000_100F,
    ENC_ECALL, ENC_EBREAK, ENC_MRET, ENC_WFI,
    32'h0000_1073, 32'h0000_2073, 32'h0000_3073,
    32'h0000_5073, 32'h0000_6073, 32'h0000_7073
  };

endpackage

// ----- sv/rvd_classify.sv -----
// Mask/match classifier: parallel compare against the encoding table.
// Depends on rvd_pkg.
module rvd_classify import rvd_pkg::*; (
  input  logic [WORD_W-1:0] word,
  output class_t            inst_class
);

  // walk from the last entry down so the lowest matching entry wins
  always_comb begin
    inst_class = CLS_NONE;
    for (int i = NUM_ENC - 1; i >= 0; i--) begin
      if ((word & ENC_MASK[i]) == ENC_MATCH[i]) begin
        inst_class = CLASS_W'(i + 1);
      end
    end
  end

endmodule

// ----- sv/rvd_imm_gen.sv -----
// Immediate builder: picks the format from the class and assembles it.
// Depends on rvd_pkg.
module rvd_imm_gen import rvd_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  class_t            inst_class,
  output imm_t              imm
);

  always_comb begin
    imm.value   = '0;
    imm.csr_imm = 1'b0;
    if (inst_class inside {[CLS_ADDI:CLS_ANDI], CLS_JALR, [CLS_LB:CLS_LHU],
                           CLS_FENCE, CLS_FENCE_I}) begin
      imm.value = {{20{word[31]}}, word[31:20]};
    end else if (inst_class inside {[CLS_SLLI:CLS_SRAI]}) begin
      imm.value = {27'd0, word[24:20]};
    end else if (inst_class inside {[CLS_SB:CLS_SW]}) begin
      imm.value = {{20{word[31]}}, word[31:25], word[11:7]};
    end else if (inst_class inside {[CLS_BEQ:CLS_BGEU]}) begin
      imm.value = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
    end else if (inst_class inside {CLS_LUI, CLS_AUIPC}) begin
      imm.value = word & UPPER_MASK;
    end else if (inst_class == CLS_JAL) begin
      imm.value = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
    end else if (inst_class inside {[CLS_CSRRWI:CLS_CSRRCI]}) begin
      imm.value   = {27'd0, word[19:15]};
      imm.csr_imm = 1'b1;
    end
  end

endmodule

// ----- sv/rv32i_instruction_decoder.sv -----
// RV32I + Zicsr instruction decoder, top level.
// Datapath: input register, then decode logic into the result register.
// Throughput: one word per cycle while out_ready is held high; each stage
// loads when it is empty or when the stage after it is taking its word.
// Reset (rst_n low, synchronous) empties both stages; payload is not reset.
// Depends on rvd_pkg, rvd_classify, rvd_imm_gen.
module rv32i_instruction_decoder import rvd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [WORD_W-1:0]  in_instruction_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CLASS_W-1:0] out_inst_class,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src1_reg,
  output logic [4:0]         out_src2_reg,
  output logic [2:0]         out_func3_field,
  output logic [6:0]         out_func7_field,
  output logic [11:0]        out_csr_number,
  output logic [4:0]         out_shift_amount,
  output logic signed [31:0] out_immediate,
  output logic               out_csr_uses_imm
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0] word_r;
  logic              out_valid_r, out_valid_nxt;
  logic              s2_ready;
  logic              s1_adv;
  logic              in_acc;

  class_t            cls;
  imm_t              imm;

  class_t            cls_r;
  logic [WORD_W-1:0] res_word_r;
  imm_t              imm_r;

  assign s2_ready = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign in_acc   = in_valid && in_ready;
  assign s1_adv   = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  rvd_classify u_classify (
    .word       (word_r),
    .inst_class (cls)
  );

  rvd_imm_gen u_imm_gen (
    .word       (word_r),
    .inst_class (cls),
    .imm        (imm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      word_r <= in_instruction_word;
    end
    if (s1_adv) begin
      cls_r      <= cls;
      res_word_r <= word_r;
      imm_r      <= imm;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_inst_class   = cls_r;
  assign out_dest_reg     = res_word_r[11:7];
  assign out_src1_reg     = res_word_r[19:15];
  assign out_src2_reg     = res_word_r[24:20];
  assign out_func3_field  = res_word_r[14:12];
  assign out_func7_field  = res_word_r[31:25];
  assign out_csr_number   = res_word_r[31:20];
  assign out_shift_amount = res_word_r[24:20];
  assign out_immediate    = signed'(imm_r.value);
  assign out_csr_uses_imm = imm_r.csr_imm;

endmodule

// ----- sv/rvd_checker.sv -----
// Port-level checker for the decoder, bound to the top level.
// Depends on rvd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rvd_checker import rvd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CLASS_W-1:0] out_inst_class,
  input logic [4:0]         out_src2_reg,
  input logic [6:0]         out_func7_field,
  input logic [11:0]        out_csr_number,
  input logic [4:0]         out_shift_amount,
  input logic signed [31:0] out_immediate,
  input logic               out_csr_uses_imm
);

  logic                      out_stall;
  logic [CLASS_W+WORD_W-1:0] out_key;
  logic                      csr_flag_ok;
  logic                      fields_agree;
  logic                      unknown_clean;

  assign out_stall = out_valid && !out_ready;
  assign out_key   = {out_inst_class, out_immediate};

  // flag only on the three CSR-immediate classes, and on all of them
  assign csr_flag_ok = out_csr_uses_imm ==
                       (out_inst_class inside {CLS_CSRRWI, CLS_CSRRSI, CLS_CSRRCI});

  // fields come from one word
  assign fields_agree = (out_shift_amount == out_src2_reg) &&
                        (out_csr_number[4:0] == out_src2_reg) &&
                        (out_csr_number[11:5] == out_func7_field);

  assign unknown_clean = (out_inst_class != CLS_NONE) ||
                         (out_immediate == 32'sd0 && !out_csr_uses_imm);

  // a stalled word keeps its class and immediate
  `RVD_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_key), "held word changed")

  `RVD_ASSERT(a_csr_flag, clk, rst_n, out_valid |-> csr_flag_ok, "csr immediate flag disagrees with class")

  `RVD_ASSERT(a_fields, clk, rst_n, out_valid |-> fields_agree, "overlapping fields disagree")

  `RVD_ASSERT(a_unknown, clk, rst_n, out_valid |-> unknown_clean, "unknown word has an immediate")

  `RVD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind rv32i_instruction_decoder rvd_checker u_rvd_checker (.*);
